// ----- rtl/nss_pkg.sv -----
package nss_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int DIST_W  = 17;
  localparam int COUNT_W = 7;
  localparam int SCORE_W = 18;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 18'h3FFFF;

  // round half up: add half an output LSB before dropping the 14 fraction bits
  localparam logic [34:0] ROUND_HALF = 35'd8192;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register select is paddr bit 2 (byte address 4*i)
  localparam logic REG_MAX_DISTANCE = 1'b0;
  localparam logic REG_ENTRY_COUNT  = 1'b1;
  localparam int   PADDR_W          = 3;

  typedef struct packed {
    logic               op;
    logic [5:0]         slot;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [15:0]        half_length;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [5:0]         match_index;
    logic [SCORE_W-1:0] match_score;
  } out_t;

  typedef struct packed {
    logic [DIST_W-1:0]  max_distance;
    logic [COUNT_W-1:0] entry_count;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [15:0]        half_length;
  } entry_t;

  typedef struct packed {
    logic             write_entry;
    logic             load_query;
    logic             issue;
    logic [IDX_W-1:0] issue_idx;
    logic             emit;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_empty;
  } dp_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

endpackage

// ----- rtl/nearest_segment_search_top.sv -----
// Nearest line segment search.
// Input channel: an item on item_i transfers at a rising edge with start high
// and busy low. op = write stores centre, direction and half length at slot
// and gives no result; busy stays low, so items may follow back to back.
// op = query scores table entries 0 .. min(entry_count, depth) - 1
// against point_x/point_y and gives one result.
// Result channel: result_o is valid for exactly one cycle while done_o is high;
// the receiver takes it at the edge that ends that cycle and cannot stall it.
// Timing: one table read per cycle feeds a five-stage scoring pipeline (read,
// offsets, four products, magnitudes, exact sum), then round, saturate and
// best-compare; done_o rises once every scanned entry has left the pipeline,
// and the next item is taken in the cycle done_o is high. The walk over the
// single-port table, one entry at a time, sets how long a query lasts.
// Configuration: APB, max_distance at 0x0, entry_count at 0x4, pready tied
// high; the user must write them only while idle, as the block does not enforce it.
// Reset: control state and registers clear (max_distance 64, entry_count 0);
// the table is not cleared and must be written before it is scanned.
module nearest_segment_search_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  nss_pkg::in_t                item_i,
  output logic                        done_o,
  output nss_pkg::out_t               result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nss_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import nss_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  nss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: owns the scan counter and the drain wait
  nss_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .op_i          (item_i.op),
    .entry_count_i (cfg.entry_count),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .busy          (busy)
  );

  // table, scoring pipeline and best tracker
  nss_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .max_distance_i (cfg.max_distance),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_o       (result_o),
    .done_o         (done_o)
  );

  // a result only follows a query in flight
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a query in flight");

  // a query transfer always occupies the block
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.op == OP_QUERY) |=> busy)
    else $error("query transfer did not raise busy");

  // a found result is within the threshold
  a_found_within: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.found) |->
      (result_o.match_score <= SCORE_W'(cfg.max_distance)))
    else $error("found result above threshold");

  // no match reports index zero
  a_miss_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.found) |-> (result_o.match_index == 6'd0))
    else $error("miss with non-zero index");

endmodule

// ----- rtl/nss_regs.sv -----
module nss_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nss_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output nss_pkg::cfg_t               cfg_o
);
  import nss_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        REG_MAX_DISTANCE: cfg_d.max_distance = pwdata[DIST_W-1:0];
        REG_ENTRY_COUNT:  cfg_d.entry_count  = pwdata[COUNT_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_distance <= DIST_W'(64);
      cfg_q.entry_count  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_DISTANCE: prdata = 32'(cfg_q.max_distance);
      REG_ENTRY_COUNT:  prdata = 32'(cfg_q.entry_count);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/nss_ctrl.sv -----
module nss_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          op_i,
  input  logic [nss_pkg::COUNT_W-1:0]   entry_count_i,
  input  nss_pkg::dp_stat_t             stat_i,
  output nss_pkg::dp_cmd_t              cmd_o,
  output logic                          busy
);
  import nss_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [31:0]      count_ext;
  logic [CNT_W-1:0] n_lim;

  // clamp the scan length to the table depth
  assign count_ext = 32'(entry_count_i);
  assign n_lim     = (count_ext > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                    : count_ext[CNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      n_q     <= n_d;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    n_d     = n_q;
    cmd_o   = '0;
    cmd_o.issue_idx = k_q[IDX_W-1:0];
    busy    = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (op_i == OP_WRITE) begin
            cmd_o.write_entry = 1'b1;
          end else begin
            cmd_o.load_query = 1'b1;
            k_d = '0;
            n_d = n_lim;
            state_d = (n_lim == '0) ? ST_DRAIN : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        k_d = k_q + CNT_W'(1);
        if (k_d == n_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat_i.pipe_empty) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/nss_dp.sv -----
module nss_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nss_pkg::in_t                item_i,
  input  logic [nss_pkg::DIST_W-1:0]  max_distance_i,
  input  nss_pkg::dp_cmd_t            cmd_i,
  output nss_pkg::dp_stat_t           stat_o,
  output nss_pkg::out_t               result_o,
  output logic                        done_o
);
  import nss_pkg::*;

  entry_t mem [TABLE_DEPTH];

  logic [31:0]      slot_ext;
  logic [IDX_W-1:0] waddr;
  logic             slot_ok;

  assign slot_ext = 32'(item_i.slot);
  assign waddr    = slot_ext[IDX_W-1:0];
  assign slot_ok  = slot_ext < 32'(TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_entry && slot_ok) begin
      mem[waddr] <= '{cx: item_i.point_x, cy: item_i.point_y, vx: item_i.dir_x,
                      vy: item_i.dir_y, half_length: item_i.half_length};
    end
  end

  // query context
  logic signed [15:0] qx_q, qy_q;
  logic [DIST_W-1:0]  limit_q;
  logic [SCORE_W-1:0] best_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic               have_q;

  // pipeline valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // stage 1: table read
  entry_t           rd_q;
  logic [IDX_W-1:0] idx1_q;

  // stage 2: offsets
  logic signed [16:0] dx_d, dy_d, dx_q, dy_q;
  logic signed [15:0] vx_q, vy_q;
  logic [29:0]        lim2_q;
  logic [IDX_W-1:0]   idx2_q;

  // stage 3: products
  logic signed [32:0] p_dyvx_q, p_dxvy_q, p_dxvx_q, p_dyvy_q;
  logic [29:0]        lim3_q;
  logic [IDX_W-1:0]   idx3_q;

  // stage 4: magnitudes
  logic signed [33:0] perp_s, along_s;
  logic [32:0]        perp_d, along_d, perp_q, along_q;
  logic [29:0]        lim4_q;
  logic [IDX_W-1:0]   idx4_q;

  // stage 5: exact sum
  logic [32:0]        over_d;
  logic [33:0]        sum_q;
  logic [IDX_W-1:0]   idx5_q;

  // final: round, saturate, compare
  logic [34:0]        rnd;
  logic [20:0]        q_full;
  logic [SCORE_W-1:0] score;
  logic               better;
  logic               found;
  logic [31:0]        best_idx_ext;

  assign dx_d = {qx_q[15], qx_q} - {rd_q.cx[15], rd_q.cx};
  assign dy_d = {qy_q[15], qy_q} - {rd_q.cy[15], rd_q.cy};

  assign perp_s  = 34'(p_dyvx_q) - 34'(p_dxvy_q);
  assign along_s = 34'(p_dxvx_q) + 34'(p_dyvy_q);
  assign perp_d  = perp_s[33]  ? 33'(-perp_s)  : 33'(perp_s);
  assign along_d = along_s[33] ? 33'(-along_s) : 33'(along_s);

  assign over_d = (along_q > 33'(lim4_q)) ? (along_q - 33'(lim4_q)) : '0;

  assign rnd    = 35'(sum_q) + ROUND_HALF;
  assign q_full = rnd[34:14];
  assign score  = (q_full > 21'(SCORE_MAX)) ? SCORE_MAX : q_full[SCORE_W-1:0];
  assign better = v5_q && (score < best_q);

  assign found        = have_q && (best_q <= SCORE_W'(limit_q));
  assign best_idx_ext = 32'(best_idx_q);

  assign stat_o.pipe_empty = !(v1_q || v2_q || v3_q || v4_q || v5_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_q <= mem[cmd_i.issue_idx];
    end
    idx1_q   <= cmd_i.issue_idx;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    vx_q     <= rd_q.vx;
    vy_q     <= rd_q.vy;
    lim2_q   <= {rd_q.half_length, 14'b0};
    idx2_q   <= idx1_q;
    p_dyvx_q <= dy_q * vx_q;
    p_dxvy_q <= dx_q * vy_q;
    p_dxvx_q <= dx_q * vx_q;
    p_dyvy_q <= dy_q * vy_q;
    lim3_q   <= lim2_q;
    idx3_q   <= idx2_q;
    perp_q   <= perp_d;
    along_q  <= along_d;
    lim4_q   <= lim3_q;
    idx4_q   <= idx3_q;
    sum_q    <= 34'(perp_q) + 34'(over_d);
    idx5_q   <= idx4_q;
    if (cmd_i.load_query) begin
      qx_q       <= item_i.point_x;
      qy_q       <= item_i.point_y;
      limit_q    <= max_distance_i;
      best_q     <= {max_distance_i, 1'b0};
      best_idx_q <= '0;
    end else if (better) begin
      best_q     <= score;
      best_idx_q <= idx5_q;
    end
    if (cmd_i.emit) begin
      result_o.found       <= found;
      result_o.match_index <= found ? best_idx_ext[5:0] : 6'd0;
      result_o.match_score <= best_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      have_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      v1_q   <= cmd_i.issue;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      done_o <= cmd_i.emit;
      if (cmd_i.load_query) begin
        have_q <= 1'b0;
      end else if (better) begin
        have_q <= 1'b1;
      end
    end
  end

endmodule
